// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the join table RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent on the following clock edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/najt_pkg.sv -----
// Shared types and constants of the node address join table.
// No dependencies; used by najt_ctrl, najt_dp and the top level.
package najt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int HB_W        = 8;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;
    localparam int OUT_W       = 16;

    localparam logic [HB_W-1:0] HEARTBEAT_RELOAD = HB_W'(3);

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED = 2'd0,
        ST_ADDED  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch request, restart the scan
        logic issue;   // read next table entry
        logic commit;  // apply result, load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_issue; // read pointer sits on the last entry
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

// ----- rtl/node_address_join_table.sv -----
// Top level of the node address join table.
// Depends on najt_pkg, najt_ctrl and najt_dp.

// Join table for network node addresses. Each input item is one 32-bit join
// request; each produces exactly one result item. The 16 entries are scanned
// in index order: a valid entry holding the same address is refreshed (its
// heartbeat reloaded) and reported as already joined with its index; with no
// match the lowest free entry takes the address, its heartbeat is reloaded
// and the occupancy count goes up by one; with no free entry the result is
// "full" with slot 0 and nothing changes. Occupancy is the count after the
// request. One item is handled at a time: the address memory has one read
// port and the scan reads and compares one entry per clock; the compare stage
// then drains, the result is committed and the controller returns to idle,
// where the next request is taken. A waiting result sits in an output
// register, so a new request is accepted and scanned while the previous
// result is pending; only the commit waits for that register to drain.
// After reset all entries are free and the count is zero; no clearing pass
// is needed.
module node_address_join_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] node_address
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // [1:0] status, [5:2] slot, [10:6] occupancy, [15:11] zero
);

    najt_pkg::t_dp_cmd w_cmd;
    najt_pkg::t_dp_sts w_sts;

    najt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    najt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_address (i_s_tdata),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_data    (o_m_tdata)
    );

endmodule

// ----- rtl/najt_ctrl.sv -----
// Sequencer of the join table: accept, scan, drain, commit.
// Depends on najt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module najt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  najt_pkg::t_dp_sts i_sts,
    output najt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.start = w_accept;
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_start_scans, i_clk, i_rst_n, w_accept, r_state == S_SCAN, "accept did not start a scan")
    `ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n, !(o_cmd.issue && (o_cmd.commit || o_cmd.start)), "commands overlap")

endmodule

// ----- rtl/najt_dp.sv -----
// Datapath of the join table: valid bits, address memory, heartbeat memory,
// scan compare, occupancy count and output register. Depends on najt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module najt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  najt_pkg::t_dp_cmd             i_cmd,
    output najt_pkg::t_dp_sts             o_sts,
    input  logic [najt_pkg::ADDR_W-1:0]   i_req_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [najt_pkg::OUT_W-1:0]    o_out_data
);

    localparam logic [najt_pkg::IDX_W-1:0] LAST_IDX = najt_pkg::IDX_W'(najt_pkg::TABLE_DEPTH - 1);

    // table storage
    logic [najt_pkg::ADDR_W-1:0] r_addr_mem [najt_pkg::TABLE_DEPTH];
    logic [najt_pkg::HB_W-1:0]   r_hb_mem   [najt_pkg::TABLE_DEPTH];
    logic [najt_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [najt_pkg::CNT_W-1:0]  r_count;

    // scan
    logic [najt_pkg::ADDR_W-1:0] r_req;
    logic [najt_pkg::IDX_W-1:0]  r_rd_idx;
    logic [najt_pkg::IDX_W-1:0]  r_cmp_idx;
    logic                        r_cmp_vld;
    logic [najt_pkg::ADDR_W-1:0] r_mem_q;
    logic                        r_found;
    logic [najt_pkg::IDX_W-1:0]  r_hit_idx;
    logic                        r_free_found;
    logic [najt_pkg::IDX_W-1:0]  r_free_idx;
    logic                        w_cmp_hit;
    logic                        w_cmp_free;

    // output register
    logic                          r_out_vld;
    najt_pkg::t_status             r_out_status;
    logic [najt_pkg::SLOT_W-1:0]   r_out_slot;
    logic [najt_pkg::OCC_W-1:0]    r_out_occ;

    // commit values
    logic [najt_pkg::CNT_W-1:0]  n_count;
    najt_pkg::t_status           n_status;
    logic [najt_pkg::SLOT_W-1:0] n_slot;

    assign w_cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (r_mem_q == r_req);
    assign w_cmp_free = r_cmp_vld && !r_valid[r_cmp_idx];

    assign o_sts.last_issue = (r_rd_idx == LAST_IDX);
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        n_count  = r_count;
        n_status = najt_pkg::ST_FULL;
        n_slot   = '0;
        if (r_found) begin
            n_status = najt_pkg::ST_JOINED;
            n_slot   = najt_pkg::SLOT_W'(r_hit_idx);
        end else if (r_free_found) begin
            n_status = najt_pkg::ST_ADDED;
            n_slot   = najt_pkg::SLOT_W'(r_free_idx);
            if (r_count < najt_pkg::CNT_W'(najt_pkg::TABLE_DEPTH)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // scan pipeline: read stage then compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (w_cmp_hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (w_cmp_free && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req    <= i_req_address;
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_cmp_idx <= r_rd_idx;
        if (w_cmp_hit && !r_found) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (w_cmp_free && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // address and heartbeat memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_mem_q <= r_addr_mem[r_rd_idx];
        end
        if (i_cmd.commit && !r_found && r_free_found) begin
            r_addr_mem[r_free_idx] <= r_req;
        end
        if (i_cmd.commit && (r_found || r_free_found)) begin
            r_hb_mem[r_found ? r_hit_idx : r_free_idx] <= najt_pkg::HEARTBEAT_RELOAD;
        end
    end

    // valid bits, count, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
                r_count   <= n_count;
                if (!r_found && r_free_found) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_slot   <= n_slot;
            r_out_occ    <= najt_pkg::OCC_W'(n_count);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {5'b0, r_out_occ, r_out_slot, r_out_status};

    `ASSERT_ALWAYS(a_count_matches, i_clk, i_rst_n, r_count == najt_pkg::CNT_W'($countones(r_valid)), "occupancy count disagrees with valid bits")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= najt_pkg::CNT_W'(najt_pkg::TABLE_DEPTH), "occupancy count past table depth")
    `ASSERT_NEXT(a_hit_is_valid, i_clk, i_rst_n, i_cmd.commit && r_found, r_valid[$past(r_hit_idx)], "refreshed entry is not valid")

endmodule
